FILE: hw/rtl/mte_pkg.sv
// Shared types, constants and register codes for the MIDI track event encoder.
// No dependencies; imported by every mte module.
`default_nettype none

package mte_pkg;

    localparam int TICK_BITS_DEF  = 20;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam int CH_W      = 4;
    localparam int PROG_W    = 7;
    localparam int TPS_W     = 12;
    localparam int SCALE_W   = 32;
    localparam int ADDR_W    = 4;
    localparam int APB_W     = 32;
    localparam int MAX_BYTES = 8;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 3;
    localparam int VLQ_MAX   = 5;

    localparam logic [1:0] FUNC_NOTE  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic [1:0] REG_CHANNEL = 2'd0;
    localparam logic [1:0] REG_PROGRAM = 2'd1;
    localparam logic [1:0] REG_PROG_EN = 2'd2;
    localparam logic [1:0] REG_TPS     = 2'd3;

    localparam logic [TPS_W-1:0] TPS_RESET = 12'd120;

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [6:0] VEL_MAX     = 7'd127;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [PROG_W-1:0] prog_num;
        logic              prog_en;
        logic [TPS_W-1:0]  tps;
    } cfg_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mte_front.sv
// Front end: input register with tick scaling, then delta and byte-list build.
// Depends on mte_pkg; pushes one byte list per productive item into mte_fifo.
`default_nettype none

module mte_front import mte_pkg::*; #(
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           in_func,
    input  wire logic [TICK_BITS-1:0] in_tick,
    input  wire logic                 in_on,
    input  wire logic [6:0]           in_note,
    input  wire logic [7:0]           in_vel,
    input  wire logic                 q_full,
    output logic                      q_push,
    output entry_t                    q_entry
);

    localparam int PROD_W = (TICK_BITS + TPS_W > SCALE_W) ? TICK_BITS + TPS_W : SCALE_W;

    logic                 s1_valid_reg;
    logic [1:0]           s1_func_reg;
    logic                 s1_on_reg;
    logic [6:0]           s1_note_reg;
    logic [7:0]           s1_vel_reg;
    logic [SCALE_W-1:0]   s1_scaled_reg;
    logic [SCALE_W-1:0]   last_tick_reg;
    logic [SCALE_W-1:0]   last_tick_next;

    logic [PROD_W-1:0]    prod;
    logic [SCALE_W-1:0]   delta;
    logic [IDX_W-1:0]     nvlq;
    logic [VLQ_MAX-1:0][6:0] grp;
    logic [7:0]           status;
    logic [7:0]           vel;
    logic                 produce;
    logic                 s1_go;

    assign prod = PROD_W'(in_tick) * PROD_W'(cfg.tps);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            last_tick_reg <= '0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s1_go) begin
                last_tick_reg <= last_tick_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            s1_func_reg   <= in_func;
            s1_on_reg     <= in_on;
            s1_note_reg   <= in_note;
            s1_vel_reg    <= in_vel;
            s1_scaled_reg <= prod[SCALE_W-1:0];
        end
    end

    assign delta = s1_scaled_reg - last_tick_reg;
    assign grp   = {{3'b000, delta[31:28]}, delta[27:21], delta[20:14], delta[13:7], delta[6:0]};

    always_comb begin
        if (|delta[31:28]) begin
            nvlq = 3'd5;
        end else if (|delta[27:21]) begin
            nvlq = 3'd4;
        end else if (|delta[20:14]) begin
            nvlq = 3'd3;
        end else if (|delta[13:7]) begin
            nvlq = 3'd2;
        end else begin
            nvlq = 3'd1;
        end
    end

    always_comb begin
        status = s1_on_reg ? (ST_NOTE_ON | {4'h0, cfg.channel})
                           : (ST_NOTE_OFF | {4'h0, cfg.channel});
        if (!s1_on_reg) begin
            vel = 8'h00;
        end else if (s1_vel_reg == 8'h00) begin
            vel = 8'h01;
        end else if (s1_vel_reg > {1'b0, VEL_MAX}) begin
            vel = {1'b0, VEL_MAX};
        end else begin
            vel = s1_vel_reg;
        end
    end

    always_comb begin
        logic [IDX_W-1:0] gi;
        gi             = '0;
        q_entry        = '0;
        produce        = 1'b0;
        last_tick_next = last_tick_reg;
        unique case (s1_func_reg)
            FUNC_START: begin
                produce          = cfg.prog_en;
                last_tick_next   = '0;
                q_entry.bytes[0] = 8'h00;
                q_entry.bytes[1] = ST_PROGRAM | {4'h0, cfg.channel};
                q_entry.bytes[2] = {1'b0, cfg.prog_num};
                q_entry.count    = 4'd3;
            end
            FUNC_END: begin
                produce          = 1'b1;
                q_entry.bytes[0] = 8'h00;
                q_entry.bytes[1] = META_STATUS;
                q_entry.bytes[2] = META_EOT;
                q_entry.bytes[3] = 8'h00;
                q_entry.count    = 4'd4;
            end
            FUNC_NOTE: begin
                produce = (s1_note_reg != 7'd0);
                if (produce) begin
                    last_tick_next = s1_scaled_reg;
                end
                for (int p = 0; p < MAX_BYTES; p++) begin
                    if (IDX_W'(p) < nvlq) begin
                        gi               = nvlq - IDX_W'(p) - 3'd1;
                        q_entry.bytes[p] = {gi != 3'd0, grp[gi]};
                    end else if (IDX_W'(p) == nvlq) begin
                        q_entry.bytes[p] = status;
                    end else if (IDX_W'(p) == nvlq + 3'd1) begin
                        q_entry.bytes[p] = {1'b0, s1_note_reg};
                    end else if (IDX_W'(p) == nvlq + 3'd2) begin
                        q_entry.bytes[p] = vel;
                    end
                end
                q_entry.count = CNT_W'(nvlq) + 4'd3;
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    assign s1_go    = s1_valid_reg && (!produce || !q_full);
    assign q_push   = s1_valid_reg && produce && !q_full;
    assign in_ready = !s1_valid_reg || s1_go;

endmodule

`default_nettype wire

FILE: hw/rtl/mte_fifo.sv
// Short queue of byte lists between the front end and the serializer.
// Depends on mte_pkg for entry_t.
`default_nettype none

module mte_fifo import mte_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t wr_data,
    input  wire logic   pop,
    output entry_t      rd_data,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    assign full    = (count_reg == CNT_QW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mte_back.sv
// Serializer: walks one byte list per entry onto the registered byte output.
// Depends on mte_pkg; pops entries from mte_fifo.
`default_nettype none

module mte_back import mte_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   q_empty,
    input  wire entry_t q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic             cur_valid_reg;
    entry_t           cur_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic out_free;
    logic cur_last;
    logic emit;

    assign out_free = !out_valid_reg || out_ready;
    assign cur_last = (CNT_W'(idx_reg) + 4'd1 == cur_reg.count);
    assign emit     = out_free && cur_valid_reg;
    assign q_pop    = !q_empty && (!cur_valid_reg || (emit && cur_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (emit) begin
                if (cur_last) begin
                    cur_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (emit) begin
            out_byte_reg <= cur_reg.bytes[idx_reg];
            out_last_reg <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/midi_track_event_encoder.sv
// Top level of the MIDI track event encoder: APB registers, front end, queue, serializer.
// Depends on mte_pkg, mte_front, mte_fifo and mte_back.
//
// Each accepted item becomes 0 to 8 track bytes on m_*, one byte per transaction, with
// m_tlast on the item's final byte: a note point gives a 1..5 byte delta VLQ plus 3 bytes,
// track start gives 3 bytes (or none when program change is off), end of track 4 bytes,
// a rest or func 3 nothing. The output port moves one byte per cycle while m_tready
// stays high and the queue holds entries. An accepted item is registered (tick multiply
// ahead of the input register), then its delta and byte list are built and pushed into
// the queue once it has room; the queue holds FIFO_DEPTH byte lists, so input keeps
// flowing while output stalls until the queue fills. Write registers only while idle.
`default_nettype none

module midi_track_event_encoder import mte_pkg::*; #(
    parameter int TICK_BITS  = TICK_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    localparam int S_DATA_W  = ((TICK_BITS + 16 + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // step_tick, note_on, note_number, velocity_in, zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // func
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // out_byte
    output logic [7:0]               m_tdata,
    output logic                     m_tlast,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready
);

    logic [CH_W-1:0]   channel_reg;
    logic [PROG_W-1:0] program_reg;
    logic              prog_en_reg;
    logic [TPS_W-1:0]  tps_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;
    cfg_t              cfg;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    entry_t q_wr;
    entry_t q_rd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg <= '0;
            program_reg <= '0;
            prog_en_reg <= 1'b1;
            tps_reg     <= TPS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHANNEL: channel_reg <= pwdata[CH_W-1:0];
                REG_PROGRAM: program_reg <= pwdata[PROG_W-1:0];
                REG_PROG_EN: prog_en_reg <= pwdata[0];
                REG_TPS:     tps_reg     <= pwdata[TPS_W-1:0];
                default:     channel_reg <= channel_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_CHANNEL: prdata[CH_W-1:0]   = channel_reg;
            REG_PROGRAM: prdata[PROG_W-1:0] = program_reg;
            REG_PROG_EN: prdata[0]          = prog_en_reg;
            REG_TPS:     prdata[TPS_W-1:0]  = tps_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg.channel  = channel_reg;
    assign cfg.prog_num = program_reg;
    assign cfg.prog_en  = prog_en_reg;
    assign cfg.tps      = tps_reg;

    mte_front #(
        .TICK_BITS (TICK_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_func  (s_tuser),
        .in_tick  (s_tdata[TICK_BITS-1:0]),
        .in_on    (s_tdata[TICK_BITS]),
        .in_note  (s_tdata[TICK_BITS+7:TICK_BITS+1]),
        .in_vel   (s_tdata[TICK_BITS+15:TICK_BITS+8]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_wr)
    );

    mte_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    mte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (q_rd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/mte_checker.sv
// Port-level checks for midi_track_event_encoder, attached by bind.
// Depends on mte_pkg for APB widths and register codes.
`default_nettype none

module mte_port_checks import mte_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [7:0]        m_tdata,
    input wire logic              m_tlast,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [APB_W-1:0]  pwdata,
    input wire logic [APB_W-1:0]  prdata
);

    // output empty and input open right after reset
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("outputs not idle after reset");

    // stalled transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output transaction changed");

    // channel write reads back
    a_chan_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && paddr == {REG_CHANNEL, 2'b00})
        |=> (paddr != {REG_CHANNEL, 2'b00} || prdata[3:0] == $past(pwdata[3:0])))
        else $error("channel register readback mismatch");

    // tick scale write reads back
    a_tps_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && paddr == {REG_TPS, 2'b00})
        |=> (paddr != {REG_TPS, 2'b00} || prdata[11:0] == $past(pwdata[11:0])))
        else $error("ticks_per_step readback mismatch");

endmodule

bind midi_track_event_encoder mte_port_checks u_mte_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

`default_nettype wire
